### hw/rtl/lbb_pkg.sv
// Shared constants, types and helpers for the LED breathing burst engine.
package lbb_pkg;

  localparam int TIME_BITS  = 16;
  localparam int CFG_DATA_W = 16;
  localparam int TIME_W     = (TIME_BITS < CFG_DATA_W) ? TIME_BITS : CFG_DATA_W;
  localparam int COUNT_W    = 8;
  localparam int LEVEL_W    = 8;
  localparam int TICKS_W    = 8;
  localparam int ELAPSED_W  = TIME_W + COUNT_W;
  localparam int TOTAL_W    = ELAPSED_W + 1;
  localparam int CFG_IDX_W  = 3;

  localparam logic [TIME_W-1:0]  MIN_PERIOD   = TIME_W'(2);
  localparam logic [TIME_W-1:0]  RST_PERIOD   = TIME_W'(2000);
  localparam logic [COUNT_W-1:0] RST_COUNT    = COUNT_W'(3);
  localparam logic [TIME_W-1:0]  RST_PAUSE    = TIME_W'(1000);
  localparam logic [LEVEL_W-1:0] RST_LVL_LOW  = LEVEL_W'(0);
  localparam logic [LEVEL_W-1:0] RST_LVL_HIGH = LEVEL_W'(255);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD   = 3'd0,
    REG_COUNT    = 3'd1,
    REG_PAUSE    = 3'd2,
    REG_LVL_LOW  = 3'd3,
    REG_LVL_HIGH = 3'd4
  } lbb_reg_t;

  typedef struct packed {
    logic [TIME_W-1:0]  period;
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  pause;
    logic [LEVEL_W-1:0] low;
    logic [LEVEL_W-1:0] high;
  } lbb_cfg_t;

  // One classified item handed from front to back
  typedef struct packed {
    logic [ELAPSED_W-1:0] elapsed;
    logic                 breath;
  } lbb_job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SPAN,
    F_UPDATE,
    F_PUSH
  } lbb_front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_POS,
    B_WAIT_POS,
    B_MUL,
    B_RAMP,
    B_WAIT_RAMP,
    B_OUT
  } lbb_back_state_t;

  // Periods below two count as two
  function automatic logic [TIME_W-1:0] eff_period(input logic [TIME_W-1:0] p);
    return (p < MIN_PERIOD) ? MIN_PERIOD : p;
  endfunction

endpackage

### hw/rtl/lbb_if.sv
// Handshake channel interfaces: tick input, level output, register writes.
interface lbb_in_if;
  logic                         valid;
  logic                         ready;
  logic [lbb_pkg::TICKS_W-1:0]  ticks_passed;
  modport source (output valid, output ticks_passed, input ready);
  modport sink   (input valid, input ticks_passed, output ready);
endinterface

interface lbb_out_if;
  logic                         valid;
  logic                         ready;
  logic [lbb_pkg::LEVEL_W-1:0]  level;
  logic                         breathing;
  modport source (output valid, output level, output breathing, input ready);
  modport sink   (input valid, input level, input breathing, output ready);
endinterface

interface lbb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lbb_pkg::CFG_IDX_W-1:0]  index;
  logic [lbb_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/lbb_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module lbb_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [lbb_pkg::ELAPSED_W-1:0]   dividend,
  input  logic [lbb_pkg::TIME_W-1:0]      divisor,
  output logic                            done,
  output logic [lbb_pkg::ELAPSED_W-1:0]   quotient,
  output logic [lbb_pkg::TIME_W-1:0]      remainder
);
  import lbb_pkg::*;

  localparam int CNT_W = $clog2(ELAPSED_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(ELAPSED_W - 1);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [ELAPSED_W-1:0] quo;
  logic [TIME_W-1:0]    rem;
  logic [TIME_W-1:0]    dvs;
  logic [TIME_W:0]      trial;
  logic                 fits;

  assign trial = {rem, quo[ELAPSED_W-1]};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[ELAPSED_W-2:0], fits};
      rem <= fits ? TIME_W'(trial - {1'b0, dvs}) : trial[TIME_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

### hw/rtl/lbb_queue.sv
// Two-entry job queue between front and back.
module lbb_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lbb_pkg::lbb_job_t push_job,
  output logic              full,
  input  logic              pop,
  output lbb_pkg::lbb_job_t head,
  output logic              empty
);
  import lbb_pkg::*;

  lbb_job_t   mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full  = (fill == 2'd2);
  assign empty = (fill == 2'd0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push && !full, pop && !empty})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_job;
    end
  end

endmodule

### hw/rtl/lbb_front.sv
// Front end: takes tick transactions, advances the cycle counter, classifies.
module lbb_front (
  input  logic              clk,
  input  logic              rst,
  input  lbb_pkg::lbb_cfg_t cfg_regs,
  lbb_in_if.sink            ticks,
  output logic              push,
  output lbb_pkg::lbb_job_t push_job,
  input  logic              full
);
  import lbb_pkg::*;

  lbb_front_state_t     state;
  lbb_front_state_t     state_next;
  logic [TICKS_W-1:0]   ticks_r;
  logic [ELAPSED_W-1:0] span_r;
  logic [ELAPSED_W-1:0] cycle_elapsed;
  logic [TOTAL_W-1:0]   total;
  logic [TOTAL_W-1:0]   sum;

  assign total = TOTAL_W'(span_r) + TOTAL_W'(cfg_regs.pause);
  assign sum   = TOTAL_W'(cycle_elapsed) + TOTAL_W'(ticks_r);

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:   if (ticks.valid) state_next = F_SPAN;
      F_SPAN:   state_next = F_UPDATE;
      F_UPDATE: state_next = F_PUSH;
      F_PUSH:   if (!full) state_next = F_IDLE;
      default:  state_next = F_IDLE;
    endcase
  end

  always_comb begin
    ticks.ready      = (state == F_IDLE);
    push             = (state == F_PUSH);
    push_job.elapsed = cycle_elapsed;
    push_job.breath  = (cycle_elapsed < span_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= F_IDLE;
      cycle_elapsed <= '0;
    end else begin
      state <= state_next;
      if (state == F_UPDATE) begin
        // wrap and drop the overshoot
        cycle_elapsed <= (sum >= total) ? '0 : sum[ELAPSED_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && ticks.valid) begin
      ticks_r <= ticks.ticks_passed;
    end
    if (state == F_SPAN) begin
      span_r <= ELAPSED_W'(cfg_regs.count) * ELAPSED_W'(eff_period(cfg_regs.period));
    end
  end

endmodule

### hw/rtl/lbb_back.sv
// Back end: position in the breath, triangle ramp, output register.
module lbb_back (
  input  logic              clk,
  input  logic              rst,
  input  lbb_pkg::lbb_cfg_t cfg_regs,
  input  lbb_pkg::lbb_job_t head,
  input  logic              empty,
  output logic              pop,
  lbb_out_if.source         result
);
  import lbb_pkg::*;

  lbb_back_state_t      state;
  lbb_back_state_t      state_next;
  lbb_job_t             job_r;
  logic [TIME_W-1:0]    period;
  logic [TIME_W-1:0]    half;
  logic [TIME_W-1:0]    x_r;
  logic [TIME_W-1:0]    span_r;
  logic [LEVEL_W-1:0]   a_r;
  logic [LEVEL_W-1:0]   diff_r;
  logic                 up_r;
  logic [ELAPSED_W-1:0] prod_r;
  logic [LEVEL_W-1:0]   level_r;
  logic                 breath_r;

  logic                 div_start;
  logic [ELAPSED_W-1:0] div_dividend;
  logic [TIME_W-1:0]    div_divisor;
  logic                 div_done;
  logic [ELAPSED_W-1:0] div_quo;
  logic [TIME_W-1:0]    div_rem;
  logic [TIME_W-1:0]    pos;
  logic [LEVEL_W-1:0]   ra;
  logic [LEVEL_W-1:0]   rb;
  logic [LEVEL_W-1:0]   mag;

  assign period = eff_period(cfg_regs.period);
  assign half   = period >> 1;
  assign pos    = div_rem;
  assign mag    = div_quo[LEVEL_W-1:0];

  lbb_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:      if (!empty) state_next = head.breath ? B_POS : B_OUT;
      B_POS:       state_next = B_WAIT_POS;
      B_WAIT_POS:  if (div_done) state_next = B_MUL;
      B_MUL:       state_next = B_RAMP;
      B_RAMP:      state_next = B_WAIT_RAMP;
      B_WAIT_RAMP: if (div_done) state_next = B_OUT;
      B_OUT:       if (result.ready) state_next = B_IDLE;
      default:     state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop              = (state == B_IDLE) && !empty;
    div_start        = (state == B_POS) || (state == B_RAMP);
    div_dividend     = (state == B_RAMP) ? prod_r : job_r.elapsed;
    div_divisor      = (state == B_RAMP) ? span_r : period;
    result.valid     = (state == B_OUT);
    result.level     = level_r;
    result.breathing = breath_r;
  end

  // rising half runs low to high, falling half high to low
  always_comb begin
    if (pos <= half) begin
      ra = cfg_regs.low;
      rb = cfg_regs.high;
    end else begin
      ra = cfg_regs.high;
      rb = cfg_regs.low;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        job_r    <= head;
        level_r  <= cfg_regs.low;
        breath_r <= 1'b0;
      end
      B_WAIT_POS: begin
        if (pos <= half) begin
          x_r    <= pos;
          span_r <= half;
        end else begin
          x_r    <= pos - half;
          span_r <= period - half;
        end
        a_r    <= ra;
        up_r   <= (rb >= ra);
        diff_r <= (rb >= ra) ? rb - ra : ra - rb;
      end
      B_MUL: begin
        prod_r <= ELAPSED_W'(x_r) * ELAPSED_W'(diff_r);
      end
      B_WAIT_RAMP: begin
        level_r  <= up_r ? a_r + mag : a_r - mag;
        breath_r <= 1'b1;
      end
      default: begin
        level_r <= level_r;
      end
    endcase
  end

endmodule

### hw/rtl/led_breathing_burst_engine.sv
// Top level of the LED breathing burst engine: register file and front/back split.
//
// Channels: 'ticks' carries one transaction per time update (milliseconds since
// the last one); 'result' returns exactly one transaction per tick transaction
// with the PWM level and a flag that is set during the breath phase; 'cfg'
// writes the five registers (0 period, 1 count, 2 pause, 3 low level,
// 4 high level). Other indices are ignored. cfg is always ready; write only
// while the block is idle.
// Steps: after the accepting edge the front multiplies, updates the counter and pushes
// into the queue, then the back pops the item. A pause item goes straight to the output
// register; a breath item makes two passes of the bit-serial divider (position in the
// period, then the ramp scaling) plus multiply and set-up states before result.valid.
// Pause items are bound by the front, which takes a new tick transaction only once it
// has pushed the last one.
// The front and a two-entry queue keep taking tick transactions while the back
// works or while its finished result waits on a stalled receiver; once the
// queue fills, ticks.ready drops.
// Reset (synchronous, rst high) loads the register defaults, clears the cycle
// counter, empties the queue and drops result.valid.
module led_breathing_burst_engine (
  input  logic      clk,
  input  logic      rst,
  lbb_in_if.sink    ticks,
  lbb_out_if.source result,
  lbb_cfg_if.sink   cfg
);
  import lbb_pkg::*;

  lbb_cfg_t cfg_regs;
  lbb_job_t push_job;
  lbb_job_t head;
  logic     push;
  logic     full;
  logic     pop;
  logic     empty;

  // register writes never stall
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.period <= RST_PERIOD;
      cfg_regs.count  <= RST_COUNT;
      cfg_regs.pause  <= RST_PAUSE;
      cfg_regs.low    <= RST_LVL_LOW;
      cfg_regs.high   <= RST_LVL_HIGH;
    end else if (cfg.valid) begin
      case (lbb_reg_t'(cfg.index))
        REG_PERIOD:   cfg_regs.period <= TIME_W'(cfg.data);
        REG_COUNT:    cfg_regs.count  <= cfg.data[COUNT_W-1:0];
        REG_PAUSE:    cfg_regs.pause  <= TIME_W'(cfg.data);
        REG_LVL_LOW:  cfg_regs.low    <= cfg.data[LEVEL_W-1:0];
        REG_LVL_HIGH: cfg_regs.high   <= cfg.data[LEVEL_W-1:0];
        default:      cfg_regs        <= cfg_regs;
      endcase
    end
  end

  // front: counter update and breath/pause classification
  lbb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_regs (cfg_regs),
    .ticks    (ticks),
    .push     (push),
    .push_job (push_job),
    .full     (full)
  );

  // decouples the two halves
  lbb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  // back: ramp evaluation and output register
  lbb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_regs (cfg_regs),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule

### tb/led_breathing_burst_engine_tb.sv
// Self-checking testbench for the LED breathing burst engine: predicts one glow result per tick.
`timescale 1ns / 100ps

module led_breathing_burst_engine_tb;
  import lbb_pkg::*;

  // Quiet-cycle limit for the watchdog, long receiver hold-off, tail after the last result
  localparam int QUIET_LIMIT  = 4000;
  localparam int STALL_CYCLES = 300;
  localparam int TAIL_CYCLES  = 100;
  localparam int PHASE_ITEMS  = 30;
  localparam int PHASES       = 6;

  // One predicted or observed result transaction
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               breathing;
  } glow_t;

  logic clk;
  logic rst;

  lbb_in_if  tick_ch ();
  lbb_out_if result_ch ();
  lbb_cfg_if cfg_ch ();

  led_breathing_burst_engine u_dut (
    .clk    (clk),
    .rst    (rst),
    .ticks  (tick_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // Tick values waiting to be offered, and glow results still owed by the block
  logic [TICKS_W-1:0] tick_backlog[$];
  glow_t              due_glows[$];

  // Shadow of the register file and of the millisecond counter that wraps after breath and pause
  lbb_cfg_t        shadow_cfg;
  longint unsigned cycle_ms;

  int unsigned fault_count;
  int unsigned quiet_cycles;
  bit          tick_fired;     // tick transaction taken at the last rising edge

  // Flow control knobs, written by the stimulus process only
  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  bit          sender_hold;
  int unsigned stall_seq;

  // Receiver-side hold-off bookkeeping, owned by the receiver process
  int unsigned stall_seen;
  int unsigned stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    fault_count++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Linear move from a_lvl toward b_lvl by x/span of the gap, truncated toward a_lvl
  function automatic logic [LEVEL_W-1:0] slide(input longint unsigned x,
                                               input longint unsigned span,
                                               input logic [LEVEL_W-1:0] a_lvl,
                                               input logic [LEVEL_W-1:0] b_lvl);
    longint unsigned gap;
    if (span == 0) return a_lvl;
    if (b_lvl >= a_lvl) begin
      gap = longint'(b_lvl) - longint'(a_lvl);
      return a_lvl + LEVEL_W'((x * gap) / span);
    end
    gap = longint'(a_lvl) - longint'(b_lvl);
    return a_lvl - LEVEL_W'((x * gap) / span);
  endfunction

  // Advances the cycle counter by one tick transaction and returns the glow it yields
  function automatic glow_t step_glow(input logic [TICKS_W-1:0] ticks);
    longint unsigned period;
    longint unsigned breath_ms;
    longint unsigned cycle_len;
    longint unsigned pos;
    longint unsigned half;
    glow_t           g;
    // periods below the minimum count as the minimum, in the length and in the ramp
    period    = (shadow_cfg.period < MIN_PERIOD) ? longint'(MIN_PERIOD)
                                                 : longint'(shadow_cfg.period);
    breath_ms = longint'(shadow_cfg.count) * period;
    cycle_len = breath_ms + longint'(shadow_cfg.pause);
    cycle_ms += longint'(ticks);
    // wrap drops any overshoot; an empty cycle keeps the counter at zero
    if (cycle_ms >= cycle_len) cycle_ms = 0;
    if (cycle_ms < breath_ms) begin
      pos  = cycle_ms % period;
      half = period / 2;
      // rising half includes the midpoint, then the falling half
      if (pos <= half) g.level = slide(pos, half, shadow_cfg.low, shadow_cfg.high);
      else g.level = slide(pos - half, period - half, shadow_cfg.high, shadow_cfg.low);
      g.breathing = 1'b1;
    end else begin
      g.level     = shadow_cfg.low;
      g.breathing = 1'b0;
    end
    return g;
  endfunction

  // Monitor: tracks register writes and tick transactions, checks result transactions
  always @(posedge clk) begin
    glow_t seen;
    glow_t want;
    if (rst) begin
      tick_fired        = 1'b0;
      cycle_ms          = 0;
      shadow_cfg.period = RST_PERIOD;
      shadow_cfg.count  = RST_COUNT;
      shadow_cfg.pause  = RST_PAUSE;
      shadow_cfg.low    = RST_LVL_LOW;
      shadow_cfg.high   = RST_LVL_HIGH;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        seen.level     = result_ch.level;
        seen.breathing = result_ch.breathing;
        if (due_glows.size() == 0) begin
          flag_mismatch($sformatf("unexpected result: level %0d breathing %0b",
                                  seen.level, seen.breathing));
        end else begin
          want = due_glows.pop_front();
          if (seen.level !== want.level)
            flag_mismatch($sformatf("level %0d, expected %0d", seen.level, want.level));
          if (seen.breathing !== want.breathing)
            flag_mismatch($sformatf("breathing %0b, expected %0b",
                                    seen.breathing, want.breathing));
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        // unknown indices leave every register untouched
        case (cfg_ch.index)
          REG_PERIOD:   shadow_cfg.period = cfg_ch.data[TIME_W-1:0];
          REG_COUNT:    shadow_cfg.count  = cfg_ch.data[COUNT_W-1:0];
          REG_PAUSE:    shadow_cfg.pause  = cfg_ch.data[TIME_W-1:0];
          REG_LVL_LOW:  shadow_cfg.low    = cfg_ch.data[LEVEL_W-1:0];
          REG_LVL_HIGH: shadow_cfg.high   = cfg_ch.data[LEVEL_W-1:0];
          default: ;
        endcase
      end
      tick_fired = tick_ch.valid && tick_ch.ready;
      if (tick_fired) due_glows.push_back(step_glow(tick_ch.ticks_passed));
    end
  end

  // Driver: offers backlog ticks on the falling edge; an offered transaction stays up until taken
  always @(negedge clk) begin
    if (rst) begin
      tick_ch.valid <= 1'b0;
    end else if (!tick_ch.valid || tick_fired) begin
      if (tick_backlog.size() != 0 && !sender_hold &&
          $urandom_range(99) >= snd_idle_pct) begin
        tick_ch.valid        <= 1'b1;
        tick_ch.ticks_passed <= tick_backlog.pop_front();
      end else begin
        tick_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off whenever one is requested
  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (stall_seq != stall_seen) begin
      stall_seen = stall_seq;
      stall_left = STALL_CYCLES - 1;
      result_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Watchdog: ends the run if no channel moves a transaction for too long
  always @(posedge clk) begin
    if (rst || (tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles < QUIET_LIMIT) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      $display("led_breathing_burst_engine_tb failed");
      $finish;
    end
  end

  // One register write transaction; valid drops again on the next falling edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Full register set; junk in the unused upper byte of the 8-bit registers
  task automatic load_setting(input int unsigned period, input int unsigned count,
                              input int unsigned pause, input int unsigned low,
                              input int unsigned high);
    write_reg(REG_PERIOD,   CFG_DATA_W'(period));
    write_reg(REG_COUNT,    {8'($urandom), 8'(count)});
    write_reg(REG_PAUSE,    CFG_DATA_W'(pause));
    write_reg(REG_LVL_LOW,  {8'($urandom), 8'(low)});
    write_reg(REG_LVL_HIGH, {8'($urandom), 8'(high)});
  endtask

  // Mostly short cycles so the counter wraps often; now and then the extremes
  task automatic random_setting();
    int unsigned p;
    int unsigned n;
    int unsigned w;
    int unsigned lo;
    int unsigned hi;
    case ($urandom_range(9))
      0: begin
        p = 65535; n = 255; w = 65535;
      end
      1: begin
        p = $urandom_range(1); n = $urandom_range(6); w = $urandom_range(4);
      end
      2: begin
        p = $urandom_range(2000, 200); n = $urandom_range(4, 1); w = $urandom_range(300);
      end
      3: begin
        p = $urandom_range(30, 2); n = 0; w = $urandom_range(40);
      end
      default: begin
        p = $urandom_range(60, 2); n = $urandom_range(8, 1); w = $urandom_range(60);
      end
    endcase
    lo = $urandom_range(255);
    hi = $urandom_range(255);
    case ($urandom_range(5))
      0: begin lo = 0;  hi = 255; end
      1: begin lo = 255; hi = 0;  end
      2: hi = lo;
      default: ;
    endcase
    load_setting(p, n, w, lo, hi);
  endtask

  // Skewed toward zero, full-scale and small steps
  function automatic logic [TICKS_W-1:0] pick_ticks();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2, 3: return TICKS_W'($urandom_range(7));
      default: return TICKS_W'($urandom);
    endcase
  endfunction

  // Block is idle once every tick is taken and every result has come back
  task automatic drain();
    while (tick_backlog.size() != 0 || tick_ch.valid || due_glows.size() != 0)
      @(posedge clk);
  endtask

  // Stimulus
  initial begin
    rst                  = 1'b1;
    tick_ch.valid        = 1'b0;
    tick_ch.ticks_passed = '0;
    result_ch.ready      = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = '0;
    cfg_ch.data          = '0;
    fault_count          = 0;
    quiet_cycles         = 0;
    sender_hold          = 1'b0;
    stall_seq            = 0;
    stall_seen           = 0;
    stall_left           = 0;
    snd_idle_pct         = 27;
    rcv_idle_pct         = 67;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset defaults, ramp start and full-scale ticks
    tick_backlog.push_back(TICKS_W'(0));
    tick_backlog.push_back(TICKS_W'(255));
    drain();

    // Short cycle: midpoint peak, falling half, second breath, pause, wrap, overshoot
    load_setting(10, 2, 5, 10, 250);
    tick_backlog.push_back(TICKS_W'(5));
    tick_backlog.push_back(TICKS_W'(1));
    tick_backlog.push_back(TICKS_W'(4));
    tick_backlog.push_back(TICKS_W'(9));
    tick_backlog.push_back(TICKS_W'(1));
    tick_backlog.push_back(TICKS_W'(4));
    tick_backlog.push_back(TICKS_W'(1));
    tick_backlog.push_back(TICKS_W'(255));
    drain();

    // Period below the minimum, no pause, high level under low level
    load_setting(1, 3, 0, 200, 17);
    repeat (6) tick_backlog.push_back(TICKS_W'(1));
    drain();

    // Empty cycle: counter pinned at zero, low level, not breathing
    write_reg(REG_COUNT, '0);
    write_reg(REG_PAUSE, '0);
    tick_backlog.push_back(TICKS_W'(0));
    tick_backlog.push_back(TICKS_W'(255));
    drain();

    // Writes to unused indices must not disturb anything
    for (int i = int'(REG_LVL_HIGH) + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
    tick_backlog.push_back(TICKS_W'(3));
    drain();

    // Largest cycle, then shrink it under the counter: restart on the next tick
    load_setting(65535, 255, 65535, 0, 255);
    repeat (5) tick_backlog.push_back(TICKS_W'(255));
    drain();
    write_reg(REG_PERIOD, CFG_DATA_W'(1000));
    write_reg(REG_COUNT, {8'($urandom), 8'(1)});
    write_reg(REG_PAUSE, '0);
    tick_backlog.push_back(TICKS_W'(0));
    drain();

    // Random part: three flow-control regimes, several register settings each
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin snd_idle_pct = 27; rcv_idle_pct = 67; end
        1: begin snd_idle_pct = 67; rcv_idle_pct = 27; end
        default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      for (int ph = 0; ph < PHASES; ph++) begin
        drain();
        // sometimes a single rewrite, leaving the counter mid-cycle
        if ($urandom_range(2) == 0)
          write_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1)),
                    CFG_DATA_W'($urandom));
        else
          random_setting();
        // long receiver hold-off while ticks keep coming: the queue fills, ready drops
        if ((mode == 0 && ph == 1) || (mode == 2 && ph == 3)) stall_seq++;
        if (mode == 1 && ph == 2) begin
          repeat (PHASE_ITEMS / 2) tick_backlog.push_back(pick_ticks());
          while (tick_backlog.size() != 0) @(posedge clk);
          // sender holds off until every owed result has been returned
          sender_hold = 1'b1;
          while (tick_ch.valid || due_glows.size() != 0) @(posedge clk);
          sender_hold = 1'b0;
          repeat (PHASE_ITEMS - PHASE_ITEMS / 2) tick_backlog.push_back(pick_ticks());
        end else begin
          repeat (PHASE_ITEMS) tick_backlog.push_back(pick_ticks());
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (due_glows.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", due_glows.size()));
    if (fault_count == 0) begin
      $display("led_breathing_burst_engine_tb passed");
    end else begin
      $display("led_breathing_burst_engine_tb failed");
    end
    $finish;
  end

endmodule
